// ----- hw/rtl/nstp_pkg.sv -----
// nstp_pkg: shared types and constants for the nested scope time profiler
// used by nstp_ctrl, nstp_dpath and nested_scope_time_profiler
`timescale 1ns / 1ps
package nstp_pkg;

   localparam int TIME_W  = 48;
   localparam int CALLS_W = 32;

   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [CALLS_W-1:0] CALLS_MAX = '1;

   // operation codes
   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ENTRY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   // register index of active_entry_count
   localparam logic REG_ACTIVE = 1'b0;

   typedef struct packed {
      logic [1:0]        op;
      logic [4:0]        entry;
      logic [TIME_W-1:0] timestamp;
      logic [5:0]        history_slot;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [TIME_W-1:0]  own_time;
      logic [TIME_W-1:0]  total_time;
      logic [CALLS_W-1:0] call_count;
      logic [5:0]         ring_position;
   } rsp_item_type;

   typedef struct packed {
      logic [4:0]        entry;
      logic [TIME_W-1:0] stamp;
   } stk_word_type;

   typedef struct packed {
      logic [TIME_W-1:0]  own;
      logic [TIME_W-1:0]  total;
      logic [CALLS_W-1:0] calls;
   } stats_type;

   typedef enum logic [1:0] {
      SRC_STACK,
      SRC_REQ,
      SRC_STEP
   } live_src_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_BEG_RD,
      S_BEG_LATCH,
      S_BEG_CHARGE,
      S_BEG_PUSH,
      S_BEG_CALL,
      S_END_RD,
      S_END_LATCH,
      S_END_CHARGE,
      S_END_RD2,
      S_END_LATCH2,
      S_END_CHARGE2,
      S_STEP_RD,
      S_STEP_WR,
      S_STEP_ADV,
      S_READ_RD,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         check;
      logic         stk_rd;
      logic         latch;
      logic         charge_own;
      logic         charge_total;
      logic         stk_wr_top;
      logic         push;
      logic         pop;
      logic         live_rd;
      live_src_type live_src;
      logic         call_wr;
      logic         step_init;
      logic         step_wr;
      logic         ring_adv;
      logic         hist_rd;
      logic         clr_wr;
      logic         respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       err;
      logic [1:0] op;
      logic       depth_zero;
      logic       lim_zero;
      logic       step_more;
      logic       clr_last;
   } sts_type;

endpackage

// ----- hw/rtl/nstp_ctrl.sv -----
// nstp_ctrl: sequencing state machine for the profiler
// depends on nstp_pkg; drives nstp_dpath through cmd/sts structs
`timescale 1ns / 1ps
module nstp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nstp_pkg::sts_type sts,
   output nstp_pkg::cmd_type cmd
);

   nstp_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nstp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.live_src = nstp_pkg::SRC_STACK;
      busy     = 1'b1;
      unique case (state_ff)
         nstp_pkg::S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = nstp_pkg::S_IDLE;
         end
         nstp_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = nstp_pkg::S_CHECK;
            end
         end
         nstp_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.err) begin
               state_in = nstp_pkg::S_RESP;
            end else begin
               unique case (sts.op)
                  nstp_pkg::OP_BEGIN:
                     state_in = sts.depth_zero ? nstp_pkg::S_BEG_PUSH : nstp_pkg::S_BEG_RD;
                  nstp_pkg::OP_END:
                     state_in = nstp_pkg::S_END_RD;
                  nstp_pkg::OP_STEP: begin
                     cmd.step_init = 1'b1;
                     state_in = sts.lim_zero ? nstp_pkg::S_STEP_ADV : nstp_pkg::S_STEP_RD;
                  end
                  default:
                     state_in = nstp_pkg::S_READ_RD;
               endcase
            end
         end
         // begin: charge the old top if any, then push and count the call
         nstp_pkg::S_BEG_RD: begin
            cmd.stk_rd = 1'b1;
            state_in   = nstp_pkg::S_BEG_LATCH;
         end
         nstp_pkg::S_BEG_LATCH: begin
            cmd.latch   = 1'b1;
            cmd.live_rd = 1'b1;
            state_in    = nstp_pkg::S_BEG_CHARGE;
         end
         nstp_pkg::S_BEG_CHARGE: begin
            cmd.charge_own   = 1'b1;
            cmd.charge_total = 1'b1;
            cmd.stk_wr_top   = 1'b1;
            state_in         = nstp_pkg::S_BEG_PUSH;
         end
         nstp_pkg::S_BEG_PUSH: begin
            cmd.push     = 1'b1;
            cmd.live_rd  = 1'b1;
            cmd.live_src = nstp_pkg::SRC_REQ;
            state_in     = nstp_pkg::S_BEG_CALL;
         end
         nstp_pkg::S_BEG_CALL: begin
            cmd.call_wr = 1'b1;
            state_in    = nstp_pkg::S_RESP;
         end
         // end: pop and charge, then charge total of the new top if any
         nstp_pkg::S_END_RD: begin
            cmd.stk_rd = 1'b1;
            cmd.pop    = 1'b1;
            state_in   = nstp_pkg::S_END_LATCH;
         end
         nstp_pkg::S_END_LATCH: begin
            cmd.latch   = 1'b1;
            cmd.live_rd = 1'b1;
            state_in    = nstp_pkg::S_END_CHARGE;
         end
         nstp_pkg::S_END_CHARGE: begin
            cmd.charge_own   = 1'b1;
            cmd.charge_total = 1'b1;
            state_in = sts.depth_zero ? nstp_pkg::S_RESP : nstp_pkg::S_END_RD2;
         end
         nstp_pkg::S_END_RD2: begin
            cmd.stk_rd = 1'b1;
            state_in   = nstp_pkg::S_END_LATCH2;
         end
         nstp_pkg::S_END_LATCH2: begin
            cmd.latch   = 1'b1;
            cmd.live_rd = 1'b1;
            state_in    = nstp_pkg::S_END_CHARGE2;
         end
         nstp_pkg::S_END_CHARGE2: begin
            cmd.charge_total = 1'b1;
            cmd.stk_wr_top   = 1'b1;
            state_in         = nstp_pkg::S_RESP;
         end
         // step: copy each active entry into the ring slot, then advance the ring
         nstp_pkg::S_STEP_RD: begin
            cmd.live_rd  = 1'b1;
            cmd.live_src = nstp_pkg::SRC_STEP;
            state_in     = nstp_pkg::S_STEP_WR;
         end
         nstp_pkg::S_STEP_WR: begin
            cmd.step_wr = 1'b1;
            state_in = sts.step_more ? nstp_pkg::S_STEP_RD : nstp_pkg::S_STEP_ADV;
         end
         nstp_pkg::S_STEP_ADV: begin
            cmd.ring_adv = 1'b1;
            state_in     = nstp_pkg::S_RESP;
         end
         nstp_pkg::S_READ_RD: begin
            cmd.hist_rd = 1'b1;
            state_in    = nstp_pkg::S_RESP;
         end
         nstp_pkg::S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = nstp_pkg::S_IDLE;
         end
         default: begin
            state_in = nstp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/nstp_dpath.sv -----
// nstp_dpath: scope stack, live counters, history ring and result register
// depends on nstp_pkg; commanded by nstp_ctrl
`timescale 1ns / 1ps
module nstp_dpath #(
   parameter int ENTRIES       = 32,
   parameter int HISTORY_DEPTH = 64,
   parameter int STACK_DEPTH   = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nstp_pkg::cmd_type      cmd,
   output nstp_pkg::sts_type      sts,
   input  nstp_pkg::req_item_type req_item,
   input  logic [5:0]             active_cnt,
   output logic                   rsp_valid,
   output nstp_pkg::rsp_item_type rsp_item
);

   localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SDW   = $clog2(STACK_DEPTH + 1);
   localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int HPW   = $clog2(HISTORY_DEPTH);
   localparam int HTOT  = ENTRIES * HISTORY_DEPTH;
   localparam int HAW   = $clog2(HTOT);
   localparam int LW    = ($clog2(ENTRIES + 1) > 6) ? $clog2(ENTRIES + 1) : 6;

   nstp_pkg::req_item_type req_ff;
   logic [1:0]             status_ff;
   logic [SDW-1:0]         depth_ff;
   logic [4:0]             e_ff;
   logic [nstp_pkg::TIME_W-1:0] d_ff;
   logic [HPW-1:0]         ring_ff;
   logic [LW-1:0]          step_i_ff;
   logic [HAW-1:0]         step_addr_ff;
   logic [HAW-1:0]         clr_ff;
   logic                   rsp_valid_ff;
   nstp_pkg::rsp_item_type rsp_ff, rsp_in;

   nstp_pkg::stk_word_type stk_mem [STACK_DEPTH];
   nstp_pkg::stk_word_type stk_rd_ff;
   logic [SAW-1:0]         stk_top_addr;

   nstp_pkg::stats_type    live_mem [ENTRIES];
   logic [ENTRIES-1:0]     live_vld_ff;
   nstp_pkg::stats_type    live_rd_ff, live_eff, live_wdata;
   logic                   live_rd_vld_ff;
   logic [EW-1:0]          live_raddr, live_addr_ff;
   logic                   live_we;

   nstp_pkg::stats_type    hist_mem [HTOT];
   nstp_pkg::stats_type    hist_rd_ff, hist_wdata;
   logic [HAW-1:0]         hist_waddr, hist_raddr;
   logic                   hist_we;

   logic [HPW-1:0]         slot_tbl [64];
   logic [LW-1:0]          ent_lim, cnt_ext;
   logic                   entry_ok;
   logic [1:0]             status_in;
   logic                   read_ok;

   // slot modulo table, worked out at elaboration
   for (genvar v = 0; v < 64; v++) begin : g_slot
      localparam int SLOT_MOD = v % HISTORY_DEPTH;
      assign slot_tbl[v] = HPW'(SLOT_MOD);
   end

   // effective entry limit and checks
   always_comb begin
      cnt_ext  = LW'(active_cnt);
      ent_lim  = (cnt_ext < LW'(ENTRIES)) ? cnt_ext : LW'(ENTRIES);
      entry_ok = LW'(req_ff.entry) < ent_lim;
      status_in = nstp_pkg::ST_OK;
      unique case (req_ff.op)
         nstp_pkg::OP_BEGIN: begin
            if (!entry_ok) status_in = nstp_pkg::ST_ENTRY;
            else if (depth_ff >= SDW'(STACK_DEPTH)) status_in = nstp_pkg::ST_FULL;
         end
         nstp_pkg::OP_END: begin
            if (depth_ff == '0) status_in = nstp_pkg::ST_EMPTY;
         end
         nstp_pkg::OP_READ: begin
            if (!entry_ok) status_in = nstp_pkg::ST_ENTRY;
         end
         default: status_in = nstp_pkg::ST_OK;
      endcase
   end

   assign sts.err        = status_in != nstp_pkg::ST_OK;
   assign sts.op         = req_ff.op;
   assign sts.depth_zero = depth_ff == '0;
   assign sts.lim_zero   = ent_lim == '0;
   assign sts.step_more  = (step_i_ff + 1'b1) < ent_lim;
   assign sts.clr_last   = clr_ff == HAW'(HTOT - 1);

   // request and status capture
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      if (cmd.check) status_ff <= status_in;
      if (cmd.latch) begin
         e_ff <= stk_rd_ff.entry;
         d_ff <= req_ff.timestamp - stk_rd_ff.stamp;
      end
   end

   // stack depth, ring position, step and clear counters
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ring_ff      <= '0;
         clr_ff       <= '0;
         step_i_ff    <= '0;
         step_addr_ff <= '0;
      end else begin
         if (cmd.push) depth_ff <= depth_ff + 1'b1;
         else if (cmd.pop) depth_ff <= depth_ff - 1'b1;
         if (cmd.ring_adv) begin
            ring_ff <= (ring_ff == HPW'(HISTORY_DEPTH - 1)) ? '0 : ring_ff + 1'b1;
         end
         if (cmd.clr_wr) clr_ff <= clr_ff + 1'b1;
         if (cmd.step_init) begin
            step_i_ff    <= '0;
            step_addr_ff <= HAW'(ring_ff);
         end else if (cmd.step_wr) begin
            step_i_ff    <= step_i_ff + 1'b1;
            step_addr_ff <= step_addr_ff + HAW'(HISTORY_DEPTH);
         end
      end
   end

   // scope stack memory
   assign stk_top_addr = SAW'(depth_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_mem[SAW'(depth_ff)] <= '{entry: req_ff.entry, stamp: req_ff.timestamp};
      end else if (cmd.stk_wr_top) begin
         stk_mem[stk_top_addr] <= '{entry: e_ff, stamp: req_ff.timestamp};
      end
      if (cmd.stk_rd) stk_rd_ff <= stk_mem[stk_top_addr];
   end

   // live counter read address
   always_comb begin
      unique case (cmd.live_src)
         nstp_pkg::SRC_STACK: live_raddr = EW'(stk_rd_ff.entry);
         nstp_pkg::SRC_REQ:   live_raddr = EW'(req_ff.entry);
         nstp_pkg::SRC_STEP:  live_raddr = EW'(step_i_ff);
         default:             live_raddr = EW'(stk_rd_ff.entry);
      endcase
   end

   // entries never written, or not written since their last step, read as zero
   assign live_eff = live_rd_vld_ff ? live_rd_ff : '0;

   // saturating charge and call count
   always_comb begin
      logic [nstp_pkg::TIME_W:0]  own_sum;
      logic [nstp_pkg::TIME_W:0]  tot_sum;
      own_sum = {1'b0, live_eff.own} + {1'b0, d_ff};
      tot_sum = {1'b0, live_eff.total} + {1'b0, d_ff};
      live_wdata = live_eff;
      if (cmd.charge_own) begin
         live_wdata.own = own_sum[nstp_pkg::TIME_W] ? nstp_pkg::TIME_MAX
                                                    : own_sum[nstp_pkg::TIME_W-1:0];
      end
      if (cmd.charge_total) begin
         live_wdata.total = tot_sum[nstp_pkg::TIME_W] ? nstp_pkg::TIME_MAX
                                                      : tot_sum[nstp_pkg::TIME_W-1:0];
      end
      if (cmd.call_wr && (live_eff.calls != nstp_pkg::CALLS_MAX)) begin
         live_wdata.calls = live_eff.calls + 1'b1;
      end
   end

   assign live_we = cmd.charge_own | cmd.charge_total | cmd.call_wr;

   // live counter memory
   always_ff @(posedge clock) begin
      if (live_we) live_mem[live_addr_ff] <= live_wdata;
      if (cmd.live_rd) begin
         live_rd_ff   <= live_mem[live_raddr];
         live_addr_ff <= live_raddr;
      end
   end

   // live valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         live_vld_ff    <= '0;
         live_rd_vld_ff <= 1'b0;
      end else begin
         if (live_we) live_vld_ff[live_addr_ff] <= 1'b1;
         else if (cmd.step_wr) live_vld_ff[EW'(step_i_ff)] <= 1'b0;
         if (cmd.live_rd) live_rd_vld_ff <= live_vld_ff[live_raddr];
      end
   end

   // history ring memory
   assign hist_we    = cmd.clr_wr | cmd.step_wr;
   assign hist_waddr = cmd.clr_wr ? clr_ff : step_addr_ff;
   assign hist_wdata = cmd.clr_wr ? '0 : live_eff;
   assign hist_raddr = HAW'(req_ff.entry) * HAW'(HISTORY_DEPTH)
                     + HAW'(slot_tbl[req_ff.history_slot]);

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      if (cmd.hist_rd) hist_rd_ff <= hist_mem[hist_raddr];
   end

   // result register
   always_comb begin
      read_ok = (req_ff.op == nstp_pkg::OP_READ) && (status_ff == nstp_pkg::ST_OK);
      rsp_in.status        = status_ff;
      rsp_in.own_time      = read_ok ? hist_rd_ff.own : '0;
      rsp_in.total_time    = read_ok ? hist_rd_ff.total : '0;
      rsp_in.call_count    = read_ok ? hist_rd_ff.calls : '0;
      rsp_in.ring_position = 6'(ring_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.respond;
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe longer than one cycle");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= SDW'(STACK_DEPTH)) else $error("stack depth beyond limit");

   a_push_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> depth_ff == SDW'($past(depth_ff) + 1'b1)) else $error("push lost");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != nstp_pkg::ST_OK) |->
         (rsp_ff.own_time == '0) && (rsp_ff.total_time == '0) && (rsp_ff.call_count == '0))
      else $error("error result carries data");

endmodule

// ----- hw/rtl/nested_scope_time_profiler.sv -----
// nested_scope_time_profiler: top level with configuration register
// depends on nstp_pkg, nstp_ctrl and nstp_dpath
`timescale 1ns / 1ps
// One item is taken at a time: busy is high from the cycle after start is
// accepted until the result strobe, and the result sits on rsp_item for the
// single cycle that rsp_valid is high; the receiver cannot stall it. A
// begin on an empty stack skips charging the old top, an end that empties
// the stack skips charging the new top, and a step walks the active entries
// in turn; the sequencer walks the single-ported stack, live counter and
// history memories, each with a registered read. After reset the block
// sweeps all ENTRIES*HISTORY_DEPTH history entries (2048 by default) to
// zero, one entry a cycle with busy high; register writes are taken meanwhile.
module nested_scope_time_profiler #(
   parameter int ENTRIES       = 32,
   parameter int HISTORY_DEPTH = 64,
   parameter int STACK_DEPTH   = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  nstp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output nstp_pkg::rsp_item_type rsp_item,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [5:0]        active_cnt_ff;
   nstp_pkg::cmd_type cmd;
   nstp_pkg::sts_type sts;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_cnt_ff <= '0;
      end else if (psel && penable && pwrite && (paddr[2] == nstp_pkg::REG_ACTIVE)) begin
         active_cnt_ff <= pwdata[5:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == nstp_pkg::REG_ACTIVE) ? {26'd0, active_cnt_ff} : '0;

   nstp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   nstp_dpath #(
      .ENTRIES       (ENTRIES),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .STACK_DEPTH   (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_item   (req_item),
      .active_cnt (active_cnt_ff),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule
